@@ design/crl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_pkg: shared types and constants
// Command and status types between controller and datapath, register
// indexes, and the root table used by the fractional power step.
// ----------------------------------------------------------------------------
package crl_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BETA   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIAS   = 3'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_STORE,
      OP_START,
      OP_READX,
      OP_SUM,
      OP_MULHI,
      OP_MULLO,
      OP_DIV,
      OP_NORM,
      OP_LOG,
      OP_PWR,
      OP_EXP,
      OP_MAG,
      OP_SHIFT,
      OP_SAT,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic last_chan;
      logic rsp_busy;
   } stat_type;

   // floor square root, one result bit per iteration
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bits;
      int i;
      rem  = v;
      res  = '0;
      bits = 64'h4000_0000_0000_0000;
      for (i = 0; i < 32; i++) begin
         if (rem >= res + bits) begin
            rem = rem - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q1.30 by the square root chain from 2.0
   function automatic logic [30:0] exp_root(input int k);
      logic [63:0] r;
      int i;
      r = 64'h8000_0000;
      for (i = 0; i < k; i++) begin
         r = isqrt64(r << 30);
      end
      return r[30:0];
   endfunction

   localparam logic [30:0] EXP_ROOTS [16] = '{
      exp_root(1),  exp_root(2),  exp_root(3),  exp_root(4),
      exp_root(5),  exp_root(6),  exp_root(7),  exp_root(8),
      exp_root(9),  exp_root(10), exp_root(11), exp_root(12),
      exp_root(13), exp_root(14), exp_root(15), exp_root(16)
   };

endpackage

@@ design/crl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [AW-1:0]        raddr,
   output logic [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/crl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_ctrl: sequencing controller
// Collects channel items, then steps the datapath through the per-channel
// normalization sequence and hands each result to the output register.
// ----------------------------------------------------------------------------
module crl_ctrl import crl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_last,
   output logic     req_ready,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);
   typedef enum logic [3:0] {
      S_IDLE, S_START, S_READX, S_SUM, S_MULHI, S_MULLO, S_DIV, S_NORM,
      S_LOG, S_PWR, S_EXP, S_MAG, S_SHIFT, S_SAT, S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_STORE;
               if (req_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.op   = OP_START;
            state_in = S_READX;
         end
         S_READX: begin
            cmd.op = OP_READX;
            if (stat.done) state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op = OP_SUM;
            if (stat.done) state_in = S_MULHI;
         end
         S_MULHI: begin
            cmd.op   = OP_MULHI;
            state_in = S_MULLO;
         end
         S_MULLO: begin
            cmd.op   = OP_MULLO;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (stat.done) state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op = OP_NORM;
            if (stat.done) state_in = S_LOG;
         end
         S_LOG: begin
            cmd.op = OP_LOG;
            if (stat.done) state_in = S_PWR;
         end
         S_PWR: begin
            cmd.op   = OP_PWR;
            state_in = S_EXP;
         end
         S_EXP: begin
            cmd.op = OP_EXP;
            if (stat.done) state_in = S_MAG;
         end
         S_MAG: begin
            cmd.op   = OP_MAG;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.op   = OP_SHIFT;
            state_in = S_SAT;
         end
         S_SAT: begin
            cmd.op   = OP_SAT;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!stat.rsp_busy || rsp_ready) begin
               cmd.op   = OP_EMIT;
               state_in = stat.last_chan ? S_IDLE : S_START;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ design/crl_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_dpath: normalization datapath
// Channel store, window sum, alpha scaling, serial divider, log2 and exp2
// units, output shift and saturation, and the result register.
// ----------------------------------------------------------------------------
module crl_dpath import crl_pkg::*; #(
   parameter int MAX_CHANNELS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic [SAMPLE_BITS-1:0]    sample_in,
   input  logic                      csr_write,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [SAMPLE_BITS-1:0]    rsp_data,
   output logic                      rsp_last
);
   localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CW      = $clog2(MAX_CHANNELS + 1);
   localparam int SUM_W   = 2 * SAMPLE_BITS + CW;
   localparam int T_W     = SUM_W + 17;
   localparam int D_W     = (T_W - 23 > 32) ? T_W - 23 : 32;
   localparam int SH_W    = $clog2(D_W);
   localparam int STEP_W  = $clog2(T_W + 1);
   localparam int IW      = ((CW > 7) ? CW : 7) + 1;
   localparam int L_W     = 24;
   localparam int P_W     = L_W + 17;
   localparam int Q_W     = 28;
   localparam int QI_W    = Q_W - 16;
   localparam int MANT_W  = 31;
   localparam int MAG_W   = SAMPLE_BITS + MANT_W;
   localparam int V_W     = MAG_W + 17;
   localparam int RS_W    = $clog2(MAG_W);
   localparam int ITER    = 16;

   // configuration
   logic [6:0]  win_ff;
   logic [31:0] alpha_ff;
   logic [15:0] beta_ff;
   logic [23:0] bias_ff;

   // control
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     chan_ff, chan_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [CW-1:0]            hi_ff, rd_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [T_W-1:0]           prod_ff;
   logic [T_W-1:0]           quo_ff;
   logic [6:0]               rem_ff;
   logic [D_W-1:0]           norm_ff;
   logic [SH_W-1:0]          sh_ff;
   logic [MANT_W-1:0]        m_ff;
   logic [15:0]              frac_ff;
   logic signed [Q_W-1:0]    q_ff;
   logic [MANT_W-1:0]        acc_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [V_W-1:0]           v_ff;
   logic [SAMPLE_BITS-1:0]   y_ff;
   logic [SAMPLE_BITS-1:0]   rsp_data_ff;
   logic                     rsp_last_ff;

   logic                   ram_we;
   logic [AW-1:0]          ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= 7'd1;
         alpha_ff <= 32'd429497;
         beta_ff  <= 16'd12288;
         bias_ff  <= 24'd65536;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW: win_ff   <= csr_data[6:0];
            CSR_ALPHA:  alpha_ff <= csr_data;
            CSR_BETA:   beta_ff  <= csr_data[15:0];
            CSR_BIAS:   bias_ff  <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   assign ram_we    = (cmd.op == OP_STORE) && (count_ff < CW'(MAX_CHANNELS));
   assign ram_raddr = (cmd.op == OP_SUM) ? rd_ff[AW-1:0] : chan_ff[AW-1:0];

   crl_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_CHANNELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (sample_in),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // window bounds
   logic [6:0]    size_v, half_lo, half_hi;
   logic [IW-1:0] chan_x, lo_v, hi_v, nm1, hi_c;
   assign size_v  = (win_ff == 7'd0) ? 7'd1 : win_ff;
   assign half_lo = (size_v - 7'd1) >> 1;
   assign half_hi = size_v >> 1;
   assign chan_x  = IW'(chan_ff);
   assign lo_v    = (chan_x > IW'(half_lo)) ? chan_x - IW'(half_lo) : '0;
   assign hi_v    = chan_x + IW'(half_hi);
   assign nm1     = IW'(count_ff) - IW'(1);
   assign hi_c    = (hi_v > nm1) ? nm1 : hi_v;

   // window sum
   logic                   issuing;
   logic [SAMPLE_BITS-1:0] rd_abs;
   logic [2*SAMPLE_BITS-1:0] rd_sq;
   assign issuing = (rd_ff <= hi_ff);
   assign rd_abs  = ram_rdata[SAMPLE_BITS-1] ? -ram_rdata : ram_rdata;
   assign rd_sq   = rd_abs * rd_abs;

   // alpha scaling
   logic [T_W-1:0] mul_hi, mul_lo;
   assign mul_hi = T_W'(alpha_ff[31:16]) * T_W'(sum_ff);
   assign mul_lo = (T_W'(alpha_ff[15:0]) * T_W'(sum_ff)) >> 16;

   // divider step
   logic [7:0]     trial;
   logic           ge;
   logic [D_W-1:0] d_raw, d_v;
   assign trial = {rem_ff, quo_ff[T_W-1]};
   assign ge    = trial >= {1'b0, size_v};
   assign d_raw = D_W'(bias_ff) + D_W'(quo_ff >> 24);
   assign d_v   = (d_raw == '0) ? D_W'(1) : d_raw;

   // log2 step
   logic [2*MANT_W-1:0] m_sq;
   logic [31:0]         m_sh;
   assign m_sq = m_ff * m_ff;
   assign m_sh = m_sq[61:30];

   // power
   int                    l_int;
   logic signed [L_W-1:0] l_val;
   logic signed [P_W-1:0] p_full;
   logic signed [Q_W-1:0] q_val;
   assign l_int  = (D_W - 17 - int'(sh_ff)) * 65536 + int'(frac_ff);
   assign l_val  = L_W'(l_int);
   assign p_full = $signed({1'b0, beta_ff}) * l_val;
   assign q_val  = -(Q_W'(p_full >>> 14));

   // exp2 of the fraction
   logic [3:0]          root_idx;
   logic [30:0]         root;
   logic [2*MANT_W-1:0] acc_mul;
   assign root_idx = step_ff[3:0] - 4'd1;
   assign root     = EXP_ROOTS[root_idx];
   assign acc_mul  = acc_ff * root;

   // magnitude, shift and saturation
   logic                   neg;
   logic [SAMPLE_BITS-1:0] x_abs;
   logic signed [QI_W:0]   s_val;
   logic [QI_W:0]          rs_val;
   logic [V_W-1:0]         shifted, lim, v_cl;
   assign neg    = x_ff[SAMPLE_BITS-1];
   assign x_abs  = neg ? SAMPLE_BITS'(-x_ff) : SAMPLE_BITS'(x_ff);
   assign s_val  = {q_ff[Q_W-1], q_ff[Q_W-1:16]} - (QI_W+1)'(30);
   assign rs_val = -s_val;
   assign lim    = neg ? (V_W'(1) << (SAMPLE_BITS - 1))
                       : ((V_W'(1) << (SAMPLE_BITS - 1)) - V_W'(1));
   assign v_cl   = (v_ff > lim) ? lim : v_ff;

   always_comb begin
      if (!s_val[QI_W] && s_val != '0) begin
         if (mag_ff != '0 && s_val >= (QI_W+1)'(17)) begin
            shifted = '1;
         end else begin
            shifted = V_W'(mag_ff) << s_val[4:0];
         end
      end else if (rs_val >= (QI_W+1)'(MAG_W)) begin
         shifted = '0;
      end else begin
         shifted = V_W'(mag_ff >> rs_val[RS_W-1:0]);
      end
   end

   // status
   always_comb begin
      stat.last_chan = (chan_ff + CW'(1) == count_ff);
      stat.rsp_busy  = rsp_valid_ff;
      case (cmd.op)
         OP_NONE:  stat.done = 1'b0;
         OP_READX: stat.done = (step_ff == STEP_W'(1));
         OP_SUM:   stat.done = !issuing && pend_ff;
         OP_DIV:   stat.done = (step_ff == STEP_W'(T_W));
         OP_NORM:  stat.done = (step_ff != '0) && norm_ff[D_W-1];
         OP_LOG:   stat.done = (step_ff == STEP_W'(ITER));
         OP_EXP:   stat.done = (step_ff == STEP_W'(ITER));
         default:  stat.done = 1'b1;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      chan_in      = chan_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (stat.done) begin
         step_in = '0;
      end else if (cmd.op == OP_NONE) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
      case (cmd.op)
         OP_STORE: begin
            if (count_ff < CW'(MAX_CHANNELS)) count_in = count_ff + CW'(1);
         end
         OP_SUM: pend_in = issuing;
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            if (stat.last_chan) begin
               count_in = '0;
               chan_in  = '0;
            end else begin
               chan_in = chan_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         chan_ff      <= '0;
         step_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         chan_ff      <= chan_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            hi_ff  <= CW'(hi_c);
            rd_ff  <= CW'(lo_v);
            sum_ff <= '0;
         end
         OP_READX: begin
            if (step_ff != '0) x_ff <= $signed(ram_rdata);
         end
         OP_SUM: begin
            if (issuing) rd_ff <= rd_ff + CW'(1);
            if (pend_ff) sum_ff <= sum_ff + SUM_W'(rd_sq);
         end
         OP_MULHI: prod_ff <= mul_hi;
         OP_MULLO: prod_ff <= prod_ff + mul_lo;
         OP_DIV: begin
            if (step_ff == '0) begin
               quo_ff <= prod_ff;
               rem_ff <= '0;
            end else begin
               rem_ff <= ge ? 7'(trial - {1'b0, size_v}) : trial[6:0];
               quo_ff <= {quo_ff[T_W-2:0], ge};
            end
         end
         OP_NORM: begin
            if (step_ff == '0) begin
               norm_ff <= d_v;
               sh_ff   <= '0;
            end else if (!norm_ff[D_W-1]) begin
               norm_ff <= norm_ff << 1;
               sh_ff   <= sh_ff + SH_W'(1);
            end
         end
         OP_LOG: begin
            if (step_ff == '0) begin
               m_ff    <= norm_ff[D_W-1 -: MANT_W];
               frac_ff <= '0;
            end else begin
               frac_ff <= {frac_ff[14:0], m_sh[31]};
               m_ff    <= m_sh[31] ? m_sh[31:1] : m_sh[30:0];
            end
         end
         OP_PWR: q_ff <= q_val;
         OP_EXP: begin
            if (step_ff == '0) begin
               acc_ff <= MANT_W'(1) << 30;
            end else if (q_ff[16 - int'(step_ff[4:0])]) begin
               acc_ff <= acc_mul[60:30];
            end
         end
         OP_MAG:   mag_ff <= MAG_W'(x_abs) * MAG_W'(acc_ff);
         OP_SHIFT: v_ff <= shifted;
         OP_SAT:   y_ff <= neg ? SAMPLE_BITS'(-v_cl) : SAMPLE_BITS'(v_cl);
         OP_EMIT: begin
            rsp_data_ff <= y_ff;
            rsp_last_ff <= stat.last_chan;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_CHANNELS))
      else $error("channel count beyond store depth");

   a_sum_in_store: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SUM && issuing) |-> (rd_ff < count_ff))
      else $error("window read beyond stored channels");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending item");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT && stat.last_chan) |=> (count_ff == '0 && chan_ff == '0))
      else $error("position state not cleared after final result");

endmodule

@@ design/cross_channel_lrn_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_channel_lrn_core: local response normalization across channels
// Collects the channel samples of one position and emits each normalized.
// ----------------------------------------------------------------------------
// Channel items are taken one per cycle while the block is idle; the item
// marked tlast starts output, and one result per stored channel follows in
// channel order, each also waiting for the output register to be free. Per
// result, the window sum over the clipped window (one store read per cycle),
// the serial divider (one quotient bit per cycle over a T-bit quotient, T =
// 2*16 + clog2(MAX_CHANNELS+1) + 17, 56 at 64 channels), the leading-one
// search of the denominator (shift of 0 to 32 at 64 channels), the 16-step
// log2 squaring loop and the 16-step exp2 root product run in turn. No new
// item is taken until the final result of the position sits in the output
// register.
// ----------------------------------------------------------------------------
module cross_channel_lrn_core import crl_pkg::*; #(
   parameter int MAX_CHANNELS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,  // [15:0] sample_value
   input  logic                     req_tlast,  // last_channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,  // [15:0] normalized_value
   output logic                     rsp_tlast,  // last_out
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);
   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   crl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   crl_dpath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .sample_in (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule
